[src/oiqs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oiqs_pkg
// Shared types and codes for the oldest-first input-queued switch.
// ----------------------------------------------------------------------------
package oiqs_pkg;

	localparam int ID_W    = 31;
	localparam int FUNC_W  = 2;
	localparam int PORT_W  = 2;
	localparam int KIND_W  = 2;
	localparam int LIMIT_W = 4;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

	// request codes
	localparam logic [FUNC_W-1:0] FUNC_ARRIVE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SEND   = 2'd2;

	// result codes
	localparam logic [KIND_W-1:0] KIND_SENT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CREDIT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DROP   = 2'd2;

	typedef logic [ID_W-1:0] id_t;

	// control from the sequencer to the compare unit
	typedef struct packed {
		logic clear;
		logic cand_vld;
	} arb_ctrl_t;

endpackage

[src/oiqs_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oiqs_req_if
// Request channel: packet arrivals and tick commands.
// ----------------------------------------------------------------------------
interface oiqs_req_if;
	logic                         valid;
	logic                         ready;
	logic [oiqs_pkg::FUNC_W-1:0]  func;
	logic [oiqs_pkg::PORT_W-1:0]  port;
	logic [oiqs_pkg::ID_W-1:0]    msg_id;

	modport source (output valid, func, port, msg_id, input ready);
	modport sink   (input valid, func, port, msg_id, output ready);
endinterface

[src/oiqs_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oiqs_rsp_if
// Response channel: sent packets, credits and drop notices.
// ----------------------------------------------------------------------------
interface oiqs_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [oiqs_pkg::KIND_W-1:0]  kind;
	logic [oiqs_pkg::PORT_W-1:0]  port_res;
	logic [oiqs_pkg::ID_W-1:0]    msg_id_res;

	modport source (output valid, kind, port_res, msg_id_res, input ready);
	modport sink   (input valid, kind, port_res, msg_id_res, output ready);
endinterface

[src/oiqs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oiqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oiqs_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

[src/oiqs_arb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oiqs_arb
// Shared compare unit: folds one entrance head per cycle into the oldest so far.
// ----------------------------------------------------------------------------
module oiqs_arb #(
	parameter int PW = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  oiqs_pkg::arb_ctrl_t ctrl,
	input  oiqs_pkg::id_t       cand_id,
	input  logic [PW-1:0]       cand_port,
	output logic                found,
	output oiqs_pkg::id_t       best_id,
	output logic [PW-1:0]       best_port
);
	import oiqs_pkg::*;

	logic          found_q;
	id_t           best_id_q;
	logic [PW-1:0] best_port_q;
	logic          take;

	// strict less-than keeps the lower port on a tie, ports arrive in order
	assign take = ctrl.cand_vld && (!found_q || (cand_id < best_id_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !ctrl.clear) begin
			best_id_q   <= cand_id;
			best_port_q <= cand_port;
		end
	end

	assign found     = found_q;
	assign best_id   = best_id_q;
	assign best_port = best_port_q;
endmodule

[src/oldest_first_input_queued_switch_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oldest_first_input_queued_switch_core
// Input-queued switch: per-port entrance FIFOs in one RAM, an exit FIFO,
// oldest-first arbitration on a period tick, credit and drop reporting.
// ----------------------------------------------------------------------------
// channel   dir  payload                         transfer when
// req       in   func, port, msg_id              req.valid & req.ready
// rsp       out  kind, port_res, msg_id_res      rsp.valid & rsp.ready
// cfg       in   cfg_wdata (exit_limit)          cfg_we
//
// One request at a time. Arrival: decode, emit on drop. Send tick: decode,
// send, emit. Period tick: decode, arbitration reading one entrance head per
// cycle through the single read port of the entrance RAM, move, emit.
// A waiting response sits in the output register; a new request is taken
// meanwhile and stalls only when it has its own response to hand over.
// Reset clears counts, pointers and the limit (8); RAM contents are not reset.
// ----------------------------------------------------------------------------
module oldest_first_input_queued_switch_core #(
	parameter int PORT_COUNT  = 3,
	parameter int ENTRY_DEPTH = 8,
	parameter int EXIT_DEPTH  = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	oiqs_req_if.sink                       req,
	oiqs_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [oiqs_pkg::LIMIT_W-1:0]   cfg_wdata
);
	import oiqs_pkg::*;

	localparam int PW   = $clog2(PORT_COUNT);
	localparam int PIW  = $clog2(PORT_COUNT + 1);
	localparam int EPW  = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
	localparam int ECW  = $clog2(ENTRY_DEPTH + 1);
	localparam int EDEP = PORT_COUNT * ENTRY_DEPTH;
	localparam int EAW  = (EDEP > 1) ? $clog2(EDEP) : 1;
	localparam int XPW  = (EXIT_DEPTH > 1) ? $clog2(EXIT_DEPTH) : 1;
	localparam int XCW  = $clog2(EXIT_DEPTH + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_ARB    = 3'd2;
	localparam logic [2:0] S_MOVE   = 3'd3;
	localparam logic [2:0] S_SEND   = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;

	logic [2:0]         state_q;
	logic [FUNC_W-1:0]  func_q;
	logic [PORT_W-1:0]  port_q;
	id_t                id_q;
	logic [LIMIT_W-1:0] limit_q;

	logic [ECW-1:0]     cnt_q [PORT_COUNT];
	logic [EPW-1:0]     ptr_q [PORT_COUNT];
	logic [XCW-1:0]     exit_cnt_q;
	logic [XPW-1:0]     exit_ptr_q;
	logic [PIW-1:0]     pidx_q;

	logic               rd_vld_s1;
	logic [PW-1:0]      rd_port_s1;

	logic [KIND_W-1:0]  res_kind_q;
	logic [PORT_W-1:0]  res_port_q;
	id_t                res_id_q;
	logic               out_vld_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic [PORT_W-1:0]  out_port_q;
	id_t                out_id_q;

	// one port is looked at per cycle, chosen by the current state
	logic [PW-1:0]      sel_port;
	logic [ECW-1:0]     cnt_sel;
	logic [EPW-1:0]     ptr_sel;
	logic [EPW-1:0]     ptr_sel_inc;
	logic [EPW-1:0]     wr_slot;
	logic               port_ok;
	logic               ent_full;
	logic               pidx_live;
	logic               exit_blocked;
	logic [XPW-1:0]     exit_wr_slot;
	logic [XPW-1:0]     exit_ptr_inc;
	logic               emit_go;

	logic               ent_we;
	logic               ent_re;
	logic [EAW-1:0]     ent_waddr;
	logic [EAW-1:0]     ent_raddr;
	id_t                ent_rdata;
	logic               exit_we;
	logic               exit_re;
	id_t                exit_rdata;

	arb_ctrl_t          arb_ctrl;
	logic               arb_found;
	id_t                arb_best_id;
	logic [PW-1:0]      arb_best_port;

	logic [31:0]        slot_sum;
	logic [31:0]        xslot_sum;

	assign port_ok   = 32'(port_q) < PORT_COUNT;
	assign pidx_live = 32'(pidx_q) < PORT_COUNT;

	always_comb begin
		case (state_q)
			S_ARB:   sel_port = PW'(pidx_q);
			S_MOVE:  sel_port = arb_best_port;
			default: sel_port = PW'(port_q);
		endcase
	end

	assign cnt_sel  = cnt_q[sel_port];
	assign ptr_sel  = ptr_q[sel_port];
	assign ent_full = 32'(cnt_sel) >= ENTRY_DEPTH;
	assign ptr_sel_inc = (32'(ptr_sel) == ENTRY_DEPTH - 1) ? '0 : ptr_sel + 1'b1;

	// tail slot wraps once at most: pointer is below depth, count at most depth
	always_comb begin
		slot_sum = 32'(ptr_sel) + 32'(cnt_sel);
		if (slot_sum >= ENTRY_DEPTH) begin
			slot_sum = slot_sum - ENTRY_DEPTH;
		end
		wr_slot = EPW'(slot_sum);
	end

	always_comb begin
		xslot_sum = 32'(exit_ptr_q) + 32'(exit_cnt_q);
		if (xslot_sum >= EXIT_DEPTH) begin
			xslot_sum = xslot_sum - EXIT_DEPTH;
		end
		exit_wr_slot = XPW'(xslot_sum);
	end

	assign exit_ptr_inc = (32'(exit_ptr_q) == EXIT_DEPTH - 1) ? '0 : exit_ptr_q + 1'b1;
	assign exit_blocked = (32'(exit_cnt_q) >= 32'(limit_q)) || (32'(exit_cnt_q) >= EXIT_DEPTH);

	assign ent_we    = (state_q == S_DECODE) && (func_q == FUNC_ARRIVE) && port_ok && !ent_full;
	assign ent_waddr = EAW'(32'(sel_port) * ENTRY_DEPTH + 32'(wr_slot));
	assign ent_re    = (state_q == S_ARB) && pidx_live;
	assign ent_raddr = EAW'(32'(sel_port) * ENTRY_DEPTH + 32'(ptr_sel));

	assign exit_we = (state_q == S_MOVE) && arb_found;
	assign exit_re = (state_q == S_DECODE) && (func_q == FUNC_SEND) && (exit_cnt_q != '0);

	assign arb_ctrl.clear    = (state_q == S_DECODE);
	assign arb_ctrl.cand_vld = (state_q == S_ARB) && rd_vld_s1;

	assign emit_go = (state_q == S_EMIT) && (!out_vld_q || rsp.ready);

	oiqs_ram #(.WIDTH(ID_W), .DEPTH(EDEP), .AW(EAW)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (id_q),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	oiqs_ram #(.WIDTH(ID_W), .DEPTH(EXIT_DEPTH), .AW(XPW)) u_exit_ram (
		.clk   (clk),
		.we    (exit_we),
		.waddr (exit_wr_slot),
		.wdata (arb_best_id),
		.re    (exit_re),
		.raddr (exit_ptr_q),
		.rdata (exit_rdata)
	);

	oiqs_arb #(.PW(PW)) u_arb (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (arb_ctrl),
		.cand_id   (ent_rdata),
		.cand_port (rd_port_s1),
		.found     (arb_found),
		.best_id   (arb_best_id),
		.best_port (arb_best_port)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pidx_q     <= '0;
			rd_vld_s1  <= 1'b0;
			exit_cnt_q <= '0;
			exit_ptr_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					pidx_q    <= '0;
					rd_vld_s1 <= 1'b0;
					case (func_q)
						FUNC_ARRIVE: begin
							state_q <= (port_ok && ent_full) ? S_EMIT : S_IDLE;
						end
						FUNC_TICK: begin
							state_q <= exit_blocked ? S_IDLE : S_ARB;
						end
						FUNC_SEND: begin
							state_q <= (exit_cnt_q != '0) ? S_SEND : S_IDLE;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_ARB: begin
					// read port pidx while the head of the previous port is compared
					rd_vld_s1 <= pidx_live && (cnt_sel != '0);
					if (pidx_live) begin
						pidx_q <= pidx_q + 1'b1;
					end else begin
						state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					if (arb_found) begin
						exit_cnt_q <= exit_cnt_q + 1'b1;
						state_q    <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SEND: begin
					exit_cnt_q <= exit_cnt_q - 1'b1;
					exit_ptr_q <= exit_ptr_inc;
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ARB) begin
			rd_port_s1 <= sel_port;
		end
	end

	// per-port entrance counts and read pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORT_COUNT; i++) begin
				cnt_q[i] <= '0;
				ptr_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < PORT_COUNT; i++) begin
				if (PW'(i) == sel_port) begin
					if (ent_we) begin
						cnt_q[i] <= cnt_sel + 1'b1;
					end else if (exit_we) begin
						cnt_q[i] <= cnt_sel - 1'b1;
						ptr_q[i] <= ptr_sel_inc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// request capture and pending response
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q <= req.func;
			port_q <= req.port;
			id_q   <= req.msg_id;
		end
		case (state_q)
			S_DECODE: begin
				res_kind_q <= KIND_DROP;
				res_port_q <= port_q;
				res_id_q   <= id_q;
			end
			S_MOVE: begin
				res_kind_q <= KIND_CREDIT;
				res_port_q <= PORT_W'(arb_best_port);
				res_id_q   <= arb_best_id;
			end
			S_SEND: begin
				res_kind_q <= KIND_SENT;
				res_port_q <= '0;
				res_id_q   <= exit_rdata;
			end
			default: begin
			end
		endcase
		if (emit_go) begin
			out_kind_q <= res_kind_q;
			out_port_q <= res_port_q;
			out_id_q   <= res_id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_go) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = out_vld_q;
	assign rsp.kind       = out_kind_q;
	assign rsp.port_res   = out_port_q;
	assign rsp.msg_id_res = out_id_q;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while another is in flight");

	a_send_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEND |-> exit_cnt_q != '0)
		else $error("send from empty exit queue");

	a_move_count: assert property (@(posedge clk) disable iff (!arst_n)
		exit_we |=> exit_cnt_q == XCW'($past(exit_cnt_q) + 1'b1))
		else $error("exit count not bumped on move");

	a_move_limit: assert property (@(posedge clk) disable iff (!arst_n)
		exit_we |-> (32'(exit_cnt_q) < EXIT_DEPTH) && (32'(exit_cnt_q) < 32'(limit_q)))
		else $error("move past exit limit");

	a_credit_port: assert property (@(posedge clk) disable iff (!arst_n)
		exit_we |-> (32'(arb_best_port) < PORT_COUNT) && (cnt_sel != '0))
		else $error("credit for empty or invalid port");
endmodule

[verif/oiqs_switch_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oiqs_switch_checker
// Watches the request and response channels of the switch core and keeps a
// shadow copy of its entrance and exit queues and of the exit limit. Every
// accepted request updates the shadow and may add one awaited notice.
// Every response transfer is compared, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module oiqs_switch_checker #(
	parameter int PORT_COUNT  = 3,
	parameter int ENTRY_DEPTH = 8,
	parameter int EXIT_DEPTH  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	oiqs_req_if                          req,
	oiqs_rsp_if                          rsp,
	input  logic                         cfg_we,
	input  logic [oiqs_pkg::LIMIT_W-1:0] cfg_wdata,
	output int                           fail_count,
	output int                           awaited,
	output int                           sent_seen,
	output int                           credit_seen,
	output int                           drop_seen
);

	import oiqs_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PORT_W-1:0] port_res;
		id_t               msg_id_res;
	} notice_t;

	id_t              entry_q [PORT_COUNT][$];
	id_t              exit_q [$];
	logic [LIMIT_W-1:0] exit_limit;
	notice_t          notices_due [$];

	// one request through the shadow switch; returns 1 when it yields a notice
	function automatic bit switch_step(input logic [FUNC_W-1:0] f,
			input logic [PORT_W-1:0] p, input id_t id, output notice_t n);
		int   cap;
		int   best;
		int   q;
		id_t  best_id;
		n = '0;
		best = -1;
		best_id = '0;
		cap = (exit_limit < EXIT_DEPTH) ? int'(exit_limit) : EXIT_DEPTH;
		case (f)
			FUNC_ARRIVE: begin
				if (p >= PORT_COUNT)
					return 1'b0;
				if (entry_q[p].size() >= ENTRY_DEPTH) begin
					n = '{KIND_DROP, p, id};
					return 1'b1;
				end
				entry_q[p].push_back(id);
				return 1'b0;
			end
			FUNC_TICK: begin
				if (exit_q.size() >= cap)
					return 1'b0;
				// strict compare keeps ties on the lower port
				for (q = 0; q < PORT_COUNT; q++) begin
					if (entry_q[q].size() != 0 && (best < 0 || entry_q[q][0] < best_id)) begin
						best = q;
						best_id = entry_q[q][0];
					end
				end
				if (best < 0)
					return 1'b0;
				void'(entry_q[best].pop_front());
				exit_q.push_back(best_id);
				n = '{KIND_CREDIT, PORT_W'(best), best_id};
				return 1'b1;
			end
			FUNC_SEND: begin
				if (exit_q.size() == 0)
					return 1'b0;
				n = '{KIND_SENT, '0, exit_q.pop_front()};
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		notice_t got;
		notice_t want;
		notice_t fresh;
		if (!arst_n) begin
			foreach (entry_q[p])
				entry_q[p].delete();
			exit_q.delete();
			notices_due.delete();
			exit_limit = LIMIT_RESET;
			fail_count = 0;
			awaited = 0;
			sent_seen = 0;
			credit_seen = 0;
			drop_seen = 0;
		end else begin
			if (cfg_we)
				exit_limit = cfg_wdata;
			// response first: a result leaving now never belongs to a request taken now
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.kind, rsp.port_res, rsp.msg_id_res};
				if (got.kind == KIND_SENT)
					sent_seen++;
				else if (got.kind == KIND_CREDIT)
					credit_seen++;
				else
					drop_seen++;
				if (notices_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("[%0t] unexpected result: kind %0d port %0d id %08h",
							$time, got.kind, got.port_res, got.msg_id_res);
				end else begin
					want = notices_due.pop_front();
					if (got.kind != want.kind || got.port_res != want.port_res ||
							got.msg_id_res != want.msg_id_res) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"[%0t] mismatch: expected kind %0d port %0d id %08h,",
								" got kind %0d port %0d id %08h"}, $time,
								want.kind, want.port_res, want.msg_id_res,
								got.kind, got.port_res, got.msg_id_res);
					end
				end
			end
			if (req.valid && req.ready && switch_step(req.func, req.port, req.msg_id, fresh))
				notices_due.push_back(fresh);
			awaited = notices_due.size();
		end
	end

endmodule

[verif/tb_oldest_first_input_queued_switch_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_oldest_first_input_queued_switch_core
// Drives the switch core with a short directed sequence (ties, largest id,
// drops, ignored requests) and then random traffic over several exit limits,
// including zero and above the exit depth. Both channel sides idle at random
// and the response side holds off once for a long stretch. The checker beside
// the core predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_oldest_first_input_queued_switch_core;

	import oiqs_pkg::*;

	localparam int PORT_COUNT      = 3;
	localparam int ENTRY_DEPTH     = 8;
	localparam int EXIT_DEPTH      = 8;
	localparam int PHASES          = 7;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int PRESSURE_PHASE  = 2;
	localparam int LONG_HOLD       = 400;
	localparam int SETTLE_CYCLES   = 16;
	localparam int IDLE_LIMIT      = 4000;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam logic [PORT_W-1:0] PORT_NONE   = 2'd3;
	localparam id_t               ID_MAX      = '1;

	localparam logic [LIMIT_W-1:0] PHASE_LIMITS [PHASES] =
		'{4'd1, 4'd0, 4'd15, 4'd2, LIMIT_RESET, 4'd5, 4'd3};

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;

	int fail_count;
	int awaited;
	int sent_seen;
	int credit_seen;
	int drop_seen;

	int n_arrive;
	int n_tick;
	int n_send;
	int n_ignored;
	bit sender_burst;
	bit stall_request;

	oiqs_req_if req_ch ();
	oiqs_rsp_if rsp_ch ();

	oldest_first_input_queued_switch_core #(
		.PORT_COUNT (PORT_COUNT),
		.ENTRY_DEPTH(ENTRY_DEPTH),
		.EXIT_DEPTH (EXIT_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	oiqs_switch_checker #(
		.PORT_COUNT (PORT_COUNT),
		.ENTRY_DEPTH(ENTRY_DEPTH),
		.EXIT_DEPTH (EXIT_DEPTH)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.awaited    (awaited),
		.sent_seen  (sent_seen),
		.credit_seen(credit_seen),
		.drop_seen  (drop_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ends the run when no transfer happens on either channel for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[%0t] no transfer for %0d cycles, %0d results outstanding",
			$time, IDLE_LIMIT, awaited);
		$display("CHECKS FAILED");
		$finish;
	end

	// response side: random ready stretches, plus one long hold on request
	initial begin
		int  r;
		int  hold_left;
		int  stretch_left;
		bit  stretch_ready;
		hold_left = 0;
		stretch_left = 0;
		stretch_ready = 1'b0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready = 1'b0;
			end else if (stretch_left > 0) begin
				stretch_left--;
				rsp_ch.ready = stretch_ready;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					stretch_ready = 1'b1;
					stretch_left = $urandom_range(30, 80);
				end else if (r < 55) begin
					stretch_ready = 1'b1;
					stretch_left = $urandom_range(0, 5);
				end else if (r < 95) begin
					stretch_ready = 1'b0;
					stretch_left = $urandom_range(0, 3);
				end else begin
					stretch_ready = 1'b0;
					stretch_left = $urandom_range(20, 50);
				end
				rsp_ch.ready = stretch_ready;
			end
		end
	end

	// offers one request after a random gap and returns at the edge it transfers
	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [PORT_W-1:0] p,
			input id_t id);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (sender_burst || r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 60);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.func = f;
		req_ch.port = p;
		req_ch.msg_id = id;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (f == FUNC_ARRIVE && p < PORT_COUNT)
			n_arrive++;
		else if (f == FUNC_TICK)
			n_tick++;
		else if (f == FUNC_SEND)
			n_send++;
		else
			n_ignored++;
	endtask

	initial begin
		int                ph;
		int                done;
		int                r;
		int                aw;
		int                tw;
		int                hot_port;
		int                k;
		logic [PORT_W-1:0] pt;
		id_t               id;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = LIMIT_RESET;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_ARRIVE;
		req_ch.port = '0;
		req_ch.msg_id = '0;
		n_arrive = 0;
		n_tick = 0;
		n_send = 0;
		n_ignored = 0;
		sender_burst = 1'b0;
		stall_request = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// nothing to do yet
		send_item(FUNC_SEND, '0, '0);
		send_item(FUNC_TICK, '0, '0);
		// equal ids on ports 0 and 1, largest id at the head of port 2
		send_item(FUNC_ARRIVE, 2'd0, 31'd5);
		send_item(FUNC_ARRIVE, 2'd1, 31'd5);
		send_item(FUNC_ARRIVE, 2'd2, ID_MAX);
		send_item(FUNC_ARRIVE, 2'd2, '0);
		send_item(FUNC_TICK, '0, '0);
		send_item(FUNC_TICK, '0, '0);
		send_item(FUNC_TICK, '0, '0);
		// out of range port and unused code are ignored
		send_item(FUNC_ARRIVE, PORT_NONE, 31'd77);
		send_item(FUNC_UNUSED, 2'd1, 31'd78);
		// fill port 0; the ninth arrival is dropped
		for (k = 0; k <= ENTRY_DEPTH; k++)
			send_item(FUNC_ARRIVE, 2'd0, id_t'(100 + k));
		// id 0 on port 2 beats id 100 on port 0
		send_item(FUNC_TICK, '0, '0);
		repeat (4) send_item(FUNC_SEND, '0, '0);

		for (ph = 0; ph < PHASES; ph++) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			while (awaited != 0)
				@(negedge clk);
			// requests without a result may still be in flight
			repeat (SETTLE_CYCLES) @(negedge clk);
			cfg_we = 1'b1;
			cfg_wdata = PHASE_LIMITS[ph];
			@(negedge clk);
			cfg_we = 1'b0;

			hot_port = $urandom_range(0, PORT_COUNT - 1);
			aw = $urandom_range(30, 60);
			tw = $urandom_range(15, 35);
			sender_burst = ($urandom_range(0, 3) == 0);
			if (ph == PRESSURE_PHASE) begin
				sender_burst = 1'b1;
				stall_request = 1'b1;
			end
			done = 0;
			while (done < ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					send_item(FUNC_UNUSED, PORT_W'($urandom), id_t'($urandom));
				end else if (r < 5) begin
					send_item(FUNC_ARRIVE, PORT_NONE, id_t'($urandom));
				end else begin
					r = $urandom_range(0, 99);
					if (r < aw) begin
						if ($urandom_range(0, 1) != 0)
							pt = PORT_W'(hot_port);
						else
							pt = PORT_W'($urandom_range(0, PORT_COUNT - 1));
						case ($urandom_range(0, 9))
							0: id = ID_MAX;
							1: id = '0;
							2, 3, 4: id = id_t'($urandom_range(0, 15));
							default: id = id_t'($urandom);
						endcase
						send_item(FUNC_ARRIVE, pt, id);
					end else if (r < aw + tw) begin
						send_item(FUNC_TICK, PORT_W'($urandom), id_t'($urandom));
					end else begin
						send_item(FUNC_SEND, PORT_W'($urandom), id_t'($urandom));
					end
					done++;
				end
			end
		end

		@(negedge clk);
		req_ch.valid = 1'b0;
		while (awaited != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("covered %0d arrivals, %0d period ticks, %0d send ticks, %0d ignored requests",
			n_arrive, n_tick, n_send, n_ignored);
		$display("over %0d exit limits: %0d sent, %0d credits, %0d drops, %0d mismatches",
			PHASES + 1, sent_seen, credit_seen, drop_seen, fail_count);
		if (fail_count == 0 && awaited == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
